// ----- rtl/core/em1_pkg.sv -----
// ----------------------------------------------------------------------------
// em1_pkg
// Shared constants and binary32 arithmetic helpers for the expm1 unit.
// ----------------------------------------------------------------------------
package em1_pkg;

  localparam logic [31:0] SatCutoff  = 32'hC18AA123;
  localparam logic [31:0] MagicBias  = 32'h4B40007F;
  localparam logic [31:0] Log2e      = 32'h3FB8AA3B;
  localparam logic [31:0] MLn2Hi     = 32'hBF317220;
  localparam logic [31:0] MLn2Lo     = 32'h350082E3;
  localparam logic [31:0] C6         = 32'h3AB5B99C;
  localparam logic [31:0] C5         = 32'h3C0913C7;
  localparam logic [31:0] C4         = 32'h3D2AAB8B;
  localparam logic [31:0] C3         = 32'h3E2AAA58;
  localparam logic [31:0] C2         = 32'h3EFFFFFF;
  localparam logic [31:0] OneF       = 32'h3F800000;
  localparam logic [31:0] DefaultNan = 32'hFFC00000;
  localparam int unsigned ScaleShift = 23;
  localparam int unsigned NumStages  = 20;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // Round a 27-bit significand window (24 bits + guard + round + sticky folded in)
  // with a biased exponent into binary32, handling overflow to infinity.
  // m holds value = m * 2^(e - 150 - 3); m[26] is the leading position.
  function automatic logic [31:0] pack_rne(input logic sgn, input logic signed [11:0] e,
                                           input logic [26:0] m);
    logic [26:0]        mm;
    logic signed [11:0] ee;
    logic [5:0]         sh;
    logic               st;
    logic [24:0]        r;
    logic               up;
    mm = m;
    ee = e;
    st = 1'b0;
    if (ee < 12'sd1) begin
      sh = (ee < -12'sd30) ? 6'd31 : 6'(12'sd1 - ee);
      for (int i = 0; i < 27; i++) begin
        if (i < sh) st = st | mm[i];
      end
      mm = (sh > 6'd26) ? 27'd0 : (mm >> sh);
      ee = 12'sd0;
    end
    up = mm[2] & (mm[1] | mm[0] | st | mm[3]);
    r = {1'b0, mm[26:3]} + 25'(up);
    if (r[24]) begin
      r = r >> 1;
      ee = ee + 12'sd1;
    end
    if (ee == 12'sd0 && r[23]) ee = 12'sd1;
    if (ee >= 12'sd255) pack_rne = {sgn, 8'hFF, 23'd0};
    else pack_rne = {sgn, ee[7:0], r[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [23:0]        ma, mb;
    logic signed [11:0] ea, eb, e;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic [26:0]        w;
    logic               found;
    s  = a[31] ^ b[31];
    ma = {(a[30:23] != 0), a[22:0]};
    mb = {(b[30:23] != 0), b[22:0]};
    ea = (a[30:23] == 0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    eb = (b[30:23] == 0) ? 12'sd1 : $signed({4'd0, b[30:23]});
    lz = 6'd0;
    found = 1'b0;
    if (is_nan(a) || is_nan(b)) fmul = DefaultNan;
    else if ((a[30:23] == 8'hFF && b[30:0] == 0) || (b[30:23] == 8'hFF && a[30:0] == 0))
      fmul = DefaultNan;
    else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) fmul = {s, 8'hFF, 23'd0};
    else if (a[30:0] == 0 || b[30:0] == 0) fmul = {s, 31'd0};
    else begin
      p = ma * mb;
      for (int i = 47; i >= 0; i--) begin
        if (!found && !p[i]) lz = lz + 6'd1;
        else found = 1'b1;
      end
      p = p << lz;
      w = {p[47:22], |p[21:0]};
      e = ea + eb - 12'sd126 - 12'(lz);
      fmul = pack_rne(s, e, w);
    end
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x, y;
    logic [7:0]         d;
    logic signed [11:0] ex, e;
    logic [27:0]        mx, my, sum;
    logic               st;
    logic [4:0]         lz;
    logic               found;
    logic [26:0]        w;
    st = 1'b0;
    lz = 5'd0;
    found = 1'b0;
    if (a[30:0] >= b[30:0]) begin
      x = a; y = b;
    end else begin
      x = b; y = a;
    end
    if (is_nan(a) || is_nan(b)) fadd = DefaultNan;
    else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) fadd = DefaultNan;
    else if (x[30:23] == 8'hFF) fadd = x;
    else if (y[30:0] == 0) begin
      if (x[30:0] == 0) fadd = {a[31] & b[31], 31'd0};
      else fadd = x;
    end else begin
      ex = (x[30:23] == 0) ? 12'sd1 : $signed({4'd0, x[30:23]});
      d  = ((x[30:23] == 0) ? 8'd1 : x[30:23]) - ((y[30:23] == 0) ? 8'd1 : y[30:23]);
      mx = {1'b0, (x[30:23] != 0), x[22:0], 3'd0};
      my = {1'b0, (y[30:23] != 0), y[22:0], 3'd0};
      for (int i = 0; i < 28; i++) begin
        if (i < d) st = st | my[i];
      end
      my = (d > 8'd27) ? 28'd0 : (my >> d);
      my[0] = my[0] | st;
      if (x[31] == y[31]) sum = mx + my;
      else sum = mx - my;
      if (sum == 0) fadd = 32'd0;
      else begin
        if (sum[27]) begin
          w = {sum[27:2], sum[1] | sum[0]};
          e = ex + 12'sd1;
        end else begin
          for (int i = 26; i >= 0; i--) begin
            if (!found && !sum[i]) lz = lz + 5'd1;
            else found = 1'b1;
          end
          if (12'(lz) > ex - 12'sd1) lz = 5'(ex - 12'sd1);
          w = sum[26:0] << lz;
          e = ex - 12'(lz);
          // A subnormal sum is already aligned to the minimum exponent; the
          // packer shifts it right once for exponent zero, so pre-shift it.
          if (!w[26]) begin
            e = 12'sd0;
            w = w << 1;
          end
        end
        fadd = pack_rne(x[31], e, w);
      end
    end
  endfunction

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        nan_in;
    logic [31:0] x;
    logic [31:0] n;
    logic [31:0] s;
    logic [31:0] t;
    logic [31:0] p;
    logic [31:0] u;
    logic [31:0] sm1;
  } em1_lane_t;

endpackage

// ----- rtl/core/em1_stage.sv -----
// ----------------------------------------------------------------------------
// em1_stage
// One pipeline register stage; the step index selects the operation it does.
// ----------------------------------------------------------------------------
module em1_stage #(
  parameter int unsigned Step = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  em1_pkg::em1_lane_t lane_i,
  output em1_pkg::em1_lane_t lane_o
);
  import em1_pkg::*;

  em1_lane_t lane_d, lane_q;

  always_comb begin
    lane_d = lane_i;
    case (Step)
      0: begin
        lane_d.nan_in = is_nan(lane_i.x);
        if (!is_nan(lane_i.x) && (lane_i.x[31] && lane_i.x[30:0] > SatCutoff[30:0]))
          lane_d.x = SatCutoff;
      end
      1: lane_d.n = fmul(lane_i.x, Log2e);
      2: lane_d.n = fadd(lane_i.n, MagicBias);
      3: begin
        lane_d.s = lane_i.n << ScaleShift;
        lane_d.n = fadd(lane_i.n, {~MagicBias[31], MagicBias[30:0]});
      end
      4: lane_d.t = fmul(lane_i.n, MLn2Hi);
      5: lane_d.t = fadd(lane_i.t, lane_i.x);
      6: lane_d.p = fmul(lane_i.n, MLn2Lo);
      7: lane_d.t = fadd(lane_i.p, lane_i.t);
      8: lane_d.p = fmul(C6, lane_i.t);
      9: lane_d.p = fadd(lane_i.p, C5);
      10: lane_d.p = fmul(lane_i.p, lane_i.t);
      11: lane_d.p = fadd(lane_i.p, C4);
      12: lane_d.p = fmul(lane_i.p, lane_i.t);
      13: lane_d.p = fadd(lane_i.p, C3);
      14: lane_d.p = fmul(lane_i.p, lane_i.t);
      15: lane_d.p = fadd(lane_i.p, C2);
      16: begin
        lane_d.p   = fmul(lane_i.p, lane_i.t);
        lane_d.u   = fmul(lane_i.t, lane_i.s);
        lane_d.sm1 = fadd(lane_i.s, {~OneF[31], OneF[30:0]});
      end
      17: lane_d.p = fmul(lane_i.p, lane_i.u);
      18: lane_d.p = fadd(lane_i.p, lane_i.u);
      default: begin
        lane_d.p = fadd(lane_i.p, lane_i.sm1);
        if (is_nan(lane_d.p)) lane_d.p = DefaultNan;
        if (lane_i.nan_in) lane_d.p = lane_i.x | 32'h0040_0000;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;
endmodule

// ----- rtl/core/expm1_negative_f32_unit.sv -----
// ----------------------------------------------------------------------------
// expm1_negative_f32_unit
// Pipelined binary32 exp(x)-1 for arguments at or below zero.
// ----------------------------------------------------------------------------
// The unit takes one argument per clock and returns its result after twenty
// register stages, each registering one step: input saturation, then rounded
// binary32 multiplies and adds. busy is always low, so a transfer happens whenever
// start is high. The receiver cannot stall; each result appears for one
// cycle with done_o high and must be captured then. last_out_o follows the item.
module expm1_negative_f32_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits_i,
  input  logic        last_i,
  output logic        done_o,
  output logic [31:0] result_bits_o,
  output logic        last_out_o
);
  import em1_pkg::*;

  em1_lane_t lane_in;
  em1_lane_t lane [NumStages+1];

  // The pipeline never stalls, so it is always ready.
  assign busy = 1'b0;

  always_comb begin
    lane_in        = '0;
    lane_in.vld    = start;
    lane_in.last   = last_i;
    lane_in.x      = x_bits_i;
  end

  assign lane[0] = lane_in;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    em1_stage #(.Step(g)) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .lane_i(lane[g]),
      .lane_o(lane[g+1])
    );
  end

  assign done_o        = lane[NumStages].vld;
  assign result_bits_o = lane[NumStages].p;
  assign last_out_o    = lane[NumStages].last;

  // A NaN argument must come out quieted with its payload kept.
  a_nan_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane[NumStages-1].vld && lane[NumStages-1].nan_in |=> result_bits_o[22])
    else $error("NaN argument not quieted");

  // Every transfer in yields one result after the pipeline latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane[1].vld |-> ##(NumStages-1) done_o)
    else $error("result lost in pipeline");
endmodule
